[hdl/clrf_pkg.sv]
// Package for the clipped rectangle fill engine.
// It holds the screen geometry, command and state codes, and the box and write request types.
// No dependencies.
package clrf_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 160;
  localparam int STORE_DEPTH   = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int COORD_W       = 8;
  localparam int PIXEL_W       = 16;
  // Signed scratch width for edge coordinates such as pos_y + rect_height - 1.
  localparam int SPAN_W        = COORD_W + 2;

  typedef enum logic [1:0] {
    MODE_SCREEN  = 2'd0,
    MODE_RECT    = 2'd1,
    MODE_OUTLINE = 2'd2,
    MODE_READ    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_BOTTOM = 2'd1,
    EDGE_LEFT   = 2'd2,
    EDGE_RIGHT  = 2'd3
  } edge_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EDGE   = 5'b00010,
    ST_WALK   = 5'b00100,
    ST_RD     = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  // A clipped box, ready for the pixel walker.
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COORD_W-1:0] cols;
    logic [COORD_W-1:0] rows;
  } box_t;

  // One frame store write request from the walker.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
  } wr_req_t;

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [COORD_W-1:0] row,
                                                 input logic [COORD_W-1:0] col);
    pix_addr = ADDR_W'(int'(row) * SCREEN_WIDTH + int'(col));
  endfunction

endpackage

[hdl/clrf_if.sv]
// Handshake interfaces for the fill engine: the command channel and the result channel.
// Each carries valid, ready and the payload; no dependencies.
interface clrf_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [7:0]  rect_width;
  logic [7:0]  rect_height;
  logic [15:0] color;

  modport source (output valid, mode, pos_x, pos_y, rect_width, rect_height, color,
                  input ready);
  modport sink (input valid, mode, pos_x, pos_y, rect_width, rect_height, color,
                output ready);
endinterface

interface clrf_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_value;
  logic        drawn;

  modport source (output valid, pixel_value, drawn, input ready);
  modport sink (input valid, pixel_value, drawn, output ready);
endinterface

[hdl/clrf_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module clrf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[hdl/clrf_walker.sv]
// Pixel walker: steps through a clipped box row by row, one frame store address a cycle.
// Depends on clrf_pkg.
module clrf_walker
  import clrf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  box_t    box,
  output wr_req_t wr,
  output logic    busy
);

  logic [COORD_W-1:0] cols;
  logic [COORD_W-1:0] col_left;
  logic [COORD_W-1:0] row_left;
  logic [ADDR_W-1:0]  addr;
  logic [ADDR_W-1:0]  row_addr;
  logic [ADDR_W-1:0]  row_addr_next;

  assign row_addr_next = row_addr + ADDR_W'(SCREEN_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && col_left == COORD_W'(1) && row_left == COORD_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cols     <= box.cols;
      col_left <= box.cols;
      row_left <= box.rows;
      addr     <= box.addr;
      row_addr <= box.addr;
    end else if (busy) begin
      if (col_left == COORD_W'(1)) begin
        // End of a row: move down one line and restart at the left column.
        col_left <= cols;
        row_left <= row_left - COORD_W'(1);
        row_addr <= row_addr_next;
        addr     <= row_addr_next;
      end else begin
        col_left <= col_left - COORD_W'(1);
        addr     <= addr + ADDR_W'(1);
      end
    end
  end

  assign wr.we   = busy;
  assign wr.addr = addr;

  a_walk_counts: assert property (@(posedge clk) disable iff (rst)
    busy |-> (col_left != '0 && row_left != '0))
    else $error("walker running with an empty row or column count");

  a_walk_addr: assert property (@(posedge clk) disable iff (rst)
    busy |-> (int'(addr) < STORE_DEPTH))
    else $error("walker address beyond the frame store");

endmodule

[hdl/clipped_rectangle_fill_engine_unit.sv]
// Top level of the clipped rectangle fill engine.
// Depends on clrf_pkg, clrf_if (both interfaces), clrf_ram and clrf_walker.
//
// Usage: commands arrive on the cmd channel and each one produces exactly one
// transaction on the res channel. A command is taken when cmd.valid and
// cmd.ready are both high; cmd.ready is high only while the engine is idle, so
// one command is worked on at a time. The frame store is a single-port RAM of
// SCREEN_WIDTH x SCREEN_HEIGHT pixels; one pixel is written per cycle.
//
// Sequence: an accepted fill or outline goes to the edge state, which starts the
// pixel walker for each edge (or the whole rectangle) that survives clipping and
// skips an edge that is rejected; after the walk of the last edge, or after a
// rejected last edge, it goes to the completion state, which loads the result.
// Fill screen walks the full store. A pixel read goes through the read state to
// the completion state. cmd.ready returns at the edge that loads the result,
// together with res.valid. The write port of the frame store sets the rate.
//
// The result sits in an output register. The engine takes the next command
// while that result waits; if the receiver still stalls when the next command
// finishes, the engine holds in its completion state until res.ready frees the
// register. Reset clears the control state only; the frame store contents are
// undefined until written, and reading a pixel never written gives any value.
module clipped_rectangle_fill_engine_unit
  import clrf_pkg::*;
(
  input logic clk,
  input logic rst,
  clrf_cmd_if.sink   cmd,
  clrf_res_if.source res
);

  state_t              state;
  mode_t               mode_q;
  edge_t               edge_q;
  logic [COORD_W-1:0]  x_q;
  logic [COORD_W-1:0]  y_q;
  logic [COORD_W-1:0]  w_q;
  logic [COORD_W-1:0]  h_q;
  logic [PIXEL_W-1:0]  color_q;
  logic                drawn_q;

  logic                res_v;
  logic [PIXEL_W-1:0]  res_pixel;
  logic                res_drawn;

  // Box setup for the current edge (or the whole rectangle).
  logic [SPAN_W-1:0]   bx;
  logic [SPAN_W-1:0]   by;
  logic [COORD_W-1:0]  bw;
  logic [COORD_W-1:0]  bh;
  logic [SPAN_W-1:0]   room_x;
  logic [SPAN_W-1:0]   room_y;
  logic                box_ok;
  logic                last_edge;
  box_t                box;

  logic                rd_ok;
  logic                wk_start;
  logic                wk_busy;
  wr_req_t             wr;

  logic                ram_en;
  logic [ADDR_W-1:0]   ram_addr;
  logic [PIXEL_W-1:0]  ram_rdata;

  logic                finish_load;

  // The outline is four single-pixel-thick fills; the right and bottom edges
  // may land before column or row zero when a size is zero, which shows up as
  // a set top bit in the signed scratch width and rejects that edge.
  always_comb begin
    bx = SPAN_W'(x_q);
    by = SPAN_W'(y_q);
    bw = w_q;
    bh = h_q;
    unique case (mode_q)
      MODE_SCREEN: begin
        bx = '0;
        by = '0;
        bw = COORD_W'(SCREEN_WIDTH);
        bh = COORD_W'(SCREEN_HEIGHT);
      end
      MODE_OUTLINE: begin
        unique case (edge_q)
          EDGE_TOP: begin
            bh = COORD_W'(1);
          end
          EDGE_BOTTOM: begin
            by = SPAN_W'(y_q) + SPAN_W'(h_q) - SPAN_W'(1);
            bh = COORD_W'(1);
          end
          EDGE_LEFT: begin
            bw = COORD_W'(1);
          end
          EDGE_RIGHT: begin
            bx = SPAN_W'(x_q) + SPAN_W'(w_q) - SPAN_W'(1);
            bw = COORD_W'(1);
          end
          default: begin
            bw = '0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign box_ok = (bw != '0) && (bh != '0) && !bx[SPAN_W-1] && !by[SPAN_W-1] &&
                  (bx < SPAN_W'(SCREEN_WIDTH)) && (by < SPAN_W'(SCREEN_HEIGHT));
  assign room_x = SPAN_W'(SCREEN_WIDTH) - bx;
  assign room_y = SPAN_W'(SCREEN_HEIGHT) - by;

  // Clip width and height to the right and bottom screen edges.
  assign box.cols = (SPAN_W'(bw) > room_x) ? room_x[COORD_W-1:0] : bw;
  assign box.rows = (SPAN_W'(bh) > room_y) ? room_y[COORD_W-1:0] : bh;
  assign box.addr = pix_addr(by[COORD_W-1:0], bx[COORD_W-1:0]);

  assign last_edge = (mode_q != MODE_OUTLINE) || (edge_q == EDGE_RIGHT);
  assign rd_ok     = (x_q < COORD_W'(SCREEN_WIDTH)) && (y_q < COORD_W'(SCREEN_HEIGHT));
  assign wk_start  = (state == ST_EDGE) && box_ok;

  assign cmd.ready   = (state == ST_IDLE);
  assign finish_load = (state == ST_FINISH) && (!res_v || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            state <= (mode_t'(cmd.mode) == MODE_READ) ? ST_RD : ST_EDGE;
          end
        end
        ST_EDGE: begin
          if (box_ok) begin
            state <= ST_WALK;
          end else if (last_edge) begin
            state <= ST_FINISH;
          end
        end
        ST_WALK: begin
          if (!wk_busy) begin
            state <= last_edge ? ST_FINISH : ST_EDGE;
          end
        end
        ST_RD: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (finish_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Command fields and per-command bookkeeping.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd.valid) begin
      mode_q  <= mode_t'(cmd.mode);
      x_q     <= cmd.pos_x;
      y_q     <= cmd.pos_y;
      w_q     <= cmd.rect_width;
      h_q     <= cmd.rect_height;
      color_q <= cmd.color;
      edge_q  <= EDGE_TOP;
      drawn_q <= 1'b0;
    end else if (state == ST_EDGE) begin
      if (box_ok) begin
        drawn_q <= 1'b1;
      end else if (!last_edge) begin
        edge_q <= edge_t'(edge_q + 2'd1);
      end
    end else if (state == ST_WALK && !wk_busy && !last_edge) begin
      edge_q <= edge_t'(edge_q + 2'd1);
    end else if (state == ST_RD) begin
      drawn_q <= rd_ok;
    end
  end

  clrf_walker u_walker (
    .clk   (clk),
    .rst   (rst),
    .start (wk_start),
    .box   (box),
    .wr    (wr),
    .busy  (wk_busy)
  );

  // The walker owns the port while it runs; a read only happens in its own
  // state, after every write of earlier commands has landed.
  assign ram_en   = wr.we || (state == ST_RD && rd_ok);
  assign ram_addr = wr.we ? wr.addr : pix_addr(y_q, x_q);

  clrf_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (wr.we),
    .addr  (ram_addr),
    .wdata (color_q),
    .rdata (ram_rdata)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (finish_load) begin
      res_v <= 1'b1;
    end else if (res.ready) begin
      res_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_load) begin
      res_pixel <= (mode_q == MODE_READ && drawn_q) ? ram_rdata : '0;
      res_drawn <= drawn_q;
    end
  end

  assign res.valid       = res_v;
  assign res.pixel_value = res_pixel;
  assign res.drawn       = res_drawn;

  a_walk_in_state: assert property (@(posedge clk) disable iff (rst)
    wk_busy |-> (state == ST_WALK))
    else $error("pixel walker running outside the walk state");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(res_v) |-> $past(state == ST_FINISH))
    else $error("result loaded outside the completion state");

  a_undrawn_zero: assert property (@(posedge clk) disable iff (rst)
    (res_v && !res_drawn) |-> (res_pixel == '0))
    else $error("result without a drawn flag carries a nonzero pixel");

  a_read_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD) |-> !wr.we)
    else $error("frame store write during a pixel read");

endmodule
